// ===== src/fcc_pkg.sv =====
package fcc_pkg;

	// Input item codes
	typedef enum logic [2:0] {
		OP_CRU_WRITE = 3'd0,
		OP_CRU_READ  = 3'd1,
		OP_IRQ_LINE  = 3'd2,
		OP_DRQ_LINE  = 3'd3,
		OP_TICK      = 3'd4
	} op_t;

	// CRU bit offsets
	localparam logic [4:0] CRU_STATUS  = 5'd0;
	localparam logic [4:0] CRU_STROBE  = 5'd1;
	localparam logic [4:0] CRU_HOLD    = 5'd2;
	localparam logic [4:0] CRU_SEL_LO  = 5'd4;
	localparam logic [4:0] CRU_SEL_HI  = 5'd6;
	localparam logic [4:0] CRU_SIDE    = 5'd7;

	// Status byte bits
	localparam logic [7:0] STATUS_FIXED     = 8'h40;
	localparam logic [7:0] STATUS_SIDE      = 8'h80;
	localparam logic [7:0] STATUS_MOTOR_OFF = 8'h10;

	// Configuration registers
	localparam int unsigned REG_COUNT        = 1;
	localparam logic [0:0]  REG_MOTOR_TICKS  = 1'b0;
	localparam logic [15:0] MOTOR_TICKS_RESET = 16'd4230;

	typedef struct packed {
		op_t        opcode;
		logic [4:0] cru_bit;
		logic       bit_value;
	} in_item_t;

	typedef struct packed {
		logic [7:0] cru_byte;
		logic       halt;
		logic       interrupt_out;
		logic       motor_enable;
		logic       drive_valid;
		logic [1:0] drive_number;
		logic       drive_changed;
		logic       side_select;
	} out_item_t;

endpackage

// ===== src/floppy_card_cru_glue.sv =====
// Channel   Direction  Handshake            Payload
// in        input      in_valid/in_ready    fcc_pkg::in_item_t (opcode, cru_bit, bit_value)
// out       output     out_valid/out_ready  fcc_pkg::out_item_t (status, halt, drive, side)
// cfg       input      APB psel/penable     motor tick count at byte address 0
//
// Each item is held first in the input register, then in the result register. One item is
// accepted per cycle while the output is not stalled; the state update happens as an item
// moves from the input register into the result register.
// A stall on the output holds both registers; the input register still takes one item.
// Reset clears all state and sets the motor tick count to 4230.
module floppy_card_cru_glue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  fcc_pkg::in_item_t    in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output fcc_pkg::out_item_t   out_data,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [2:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);
	import fcc_pkg::*;

	logic [15:0] motor_ticks_q;
	logic        reg_sel;

	logic        valid_s1;
	in_item_t    item_s1;
	logic        valid_s2;
	out_item_t   result_s2;
	logic        advance;

	logic [2:0]  select_bits_q,  select_bits_d;
	logic [1:0]  cur_drive_q,    cur_drive_d;
	logic        drive_sel_q,    drive_sel_d;
	logic        side_q,         side_d;
	logic        motor_en_q,     motor_en_d;
	logic        strobe_q,       strobe_d;
	logic        hold_q,         hold_d;
	logic        irq_q,          irq_d;
	logic        drq_q,          drq_d;
	logic [15:0] countdown_q,    countdown_d;
	logic [7:0]  byte_d;
	logic        changed_d;
	logic [1:0]  sel_drive;
	logic [4:0]  sel_offset;
	logic        is_select;
	out_item_t   result_d;

	// Configuration port
	assign pready  = 1'b1;
	assign reg_sel = (paddr[2] == REG_MOTOR_TICKS);
	assign prdata  = reg_sel ? {16'd0, motor_ticks_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			motor_ticks_q <= MOTOR_TICKS_RESET;
		end else if (psel && penable && pwrite && reg_sel) begin
			motor_ticks_q <= pwdata[15:0];
		end
	end

	// Handshake between the two registers
	assign advance   = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign out_valid = valid_s2;
	assign out_data  = result_s2;

	// Hold the accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_data;
		end
	end

	// Decode drive select offsets
	assign sel_offset = item_s1.cru_bit - CRU_SEL_LO;
	assign sel_drive  = sel_offset[1:0];
	assign is_select  = (item_s1.cru_bit >= CRU_SEL_LO) && (item_s1.cru_bit <= CRU_SEL_HI);

	// Next state and result for the item in the input register
	always_comb begin
		select_bits_d = select_bits_q;
		cur_drive_d   = cur_drive_q;
		drive_sel_d   = drive_sel_q;
		side_d        = side_q;
		motor_en_d    = motor_en_q;
		strobe_d      = strobe_q;
		hold_d        = hold_q;
		irq_d         = irq_q;
		drq_d         = drq_q;
		countdown_d   = countdown_q;
		byte_d        = 8'd0;
		changed_d     = 1'b0;

		unique case (item_s1.opcode)
			OP_CRU_WRITE: begin
				if (item_s1.cru_bit == CRU_STROBE) begin
					if (item_s1.bit_value && !strobe_q) begin
						motor_en_d  = 1'b1;
						countdown_d = motor_ticks_q;
					end
					strobe_d = item_s1.bit_value;
				end else if (item_s1.cru_bit == CRU_HOLD) begin
					hold_d = item_s1.bit_value;
				end else if (is_select) begin
					if (item_s1.bit_value) begin
						select_bits_d[sel_drive] = 1'b1;
						if (!drive_sel_q || (sel_drive != cur_drive_q)) begin
							cur_drive_d = sel_drive;
							drive_sel_d = 1'b1;
							changed_d   = 1'b1;
						end
					end else begin
						select_bits_d[sel_drive] = 1'b0;
						if (drive_sel_q && (sel_drive == cur_drive_q)) begin
							drive_sel_d = 1'b0;
						end
					end
				end else if (item_s1.cru_bit == CRU_SIDE) begin
					side_d = item_s1.bit_value;
				end
			end
			OP_CRU_READ: begin
				if (item_s1.cru_bit == CRU_STATUS) begin
					byte_d = STATUS_FIXED;
					if (side_q) begin
						byte_d = byte_d | STATUS_SIDE;
					end
					if (motor_en_q) begin
						byte_d = byte_d | {4'd0, select_bits_q, 1'b0};
					end else begin
						byte_d = byte_d | STATUS_MOTOR_OFF;
					end
				end
			end
			OP_IRQ_LINE: irq_d = item_s1.bit_value;
			OP_DRQ_LINE: drq_d = item_s1.bit_value;
			OP_TICK: begin
				if (motor_en_q) begin
					if (countdown_q <= 16'd1) begin
						countdown_d = 16'd0;
						motor_en_d  = 1'b0;
					end else begin
						countdown_d = countdown_q - 16'd1;
					end
				end
			end
			default: begin
			end
		endcase

		result_d.cru_byte      = byte_d;
		result_d.halt          = hold_d && !irq_d && !drq_d && motor_en_d;
		result_d.interrupt_out = irq_d;
		result_d.motor_enable  = motor_en_d;
		result_d.drive_valid   = drive_sel_d;
		result_d.drive_number  = drive_sel_d ? cur_drive_d : 2'd0;
		result_d.drive_changed = changed_d;
		result_d.side_select   = side_d;
	end

	// Commit state and result when the item advances
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			select_bits_q <= 3'd0;
			cur_drive_q   <= 2'd0;
			drive_sel_q   <= 1'b0;
			side_q        <= 1'b0;
			motor_en_q    <= 1'b0;
			strobe_q      <= 1'b0;
			hold_q        <= 1'b0;
			irq_q         <= 1'b0;
			drq_q         <= 1'b0;
			countdown_q   <= 16'd0;
			valid_s2      <= 1'b0;
		end else begin
			if (advance) begin
				select_bits_q <= select_bits_d;
				cur_drive_q   <= cur_drive_d;
				drive_sel_q   <= drive_sel_d;
				side_q        <= side_d;
				motor_en_q    <= motor_en_d;
				strobe_q      <= strobe_d;
				hold_q        <= hold_d;
				irq_q         <= irq_d;
				drq_q         <= drq_d;
				countdown_q   <= countdown_d;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result_d;
		end
	end

	// Checks
	a_halt_needs_motor: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && result_s2.halt |-> result_s2.motor_enable)
		else $error("halt without motor enable");

	a_changed_needs_drive: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && result_s2.drive_changed |-> result_s2.drive_valid)
		else $error("drive change without a selected drive");

	a_no_drive_number: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !result_s2.drive_valid |-> result_s2.drive_number == 2'd0)
		else $error("drive number set with no drive selected");

	a_motor_off_count: assert property (@(posedge clk) disable iff (!arst_n)
		!motor_en_q |-> countdown_q == 16'd0)
		else $error("countdown left running with motor off");

	a_stall_holds_s1: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && valid_s2 && !out_ready)
		else $error("input stalled without a full pipeline");

endmodule
